FILE: sv/rvx_pkg.sv
// Shared constants, types and helpers for the RV32I subset executor.
`default_nettype none
package rvx_pkg;
    localparam int DataWordsDef = 16384;

    localparam logic [6:0] OP_REG    = 7'b0110011;
    localparam logic [6:0] OP_IMM    = 7'b0010011;
    localparam logic [6:0] OP_JALR   = 7'b1100111;
    localparam logic [6:0] OP_LOAD   = 7'b0000011;
    localparam logic [6:0] OP_JAL    = 7'b1101111;
    localparam logic [6:0] OP_BRANCH = 7'b1100011;
    localparam logic [6:0] OP_STORE  = 7'b0100011;
    localparam logic [6:0] OP_LUI    = 7'b0110111;
    localparam logic [6:0] OP_AUIPC  = 7'b0010111;
    localparam logic [31:0] HALT_WORD = 32'h0000_0073;
    localparam logic [6:0] F7_BASE   = 7'b0000000;
    localparam logic [6:0] F7_ALT    = 7'b0100000;

    // access sizes
    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_HALF = 2'd1;
    localparam logic [1:0] SZ_WORD = 2'd2;

    localparam int TDATA_IN_W  = 32;
    localparam int TDATA_OUT_W = 144;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        reg_written;
        logic [4:0]  dest_reg;
        logic [31:0] write_value;
        logic        store_done;
        logic [31:0] mem_address;
        logic [31:0] store_value;
        logic        halted;
        logic        illegal;
    } result_t;

    typedef struct packed {
        result_t    res;
        logic       is_load;
        logic [1:0] size;
        logic       halt_set;
    } exec_t;

    // Reassemble a load from the four byte lanes, byte i sits in lane (off + i) mod 4.
    function automatic logic [31:0] load_value(input logic [31:0] lanes,
                                               input logic [1:0] off,
                                               input logic [1:0] size);
        logic [31:0] raw;
        logic [1:0]  idx;
        raw = '0;
        for (int i = 0; i < 4; i++) begin
            idx = off + 2'(i);
            raw[8*i +: 8] = lanes[8*idx +: 8];
        end
        case (size)
            SZ_BYTE: load_value = {{24{raw[7]}}, raw[7:0]};
            SZ_HALF: load_value = {{16{raw[15]}}, raw[15:0]};
            default: load_value = raw;
        endcase
    endfunction
endpackage
`default_nettype wire

FILE: sv/rvx_exec.sv
// Instruction decode and execute for one item.
`default_nettype none
module rvx_exec (
    input  wire logic [31:0]  instr,
    input  wire logic [31:0]  pc,
    input  wire logic [31:0]  op_a,
    input  wire logic [31:0]  op_b,
    input  wire logic         halt_seen,
    output rvx_pkg::exec_t    ex
);
    import rvx_pkg::*;

    logic [6:0]  opc, f7;
    logic [2:0]  f3;
    logic [4:0]  rd;
    logic [31:0] imm_i, imm_s, imm_b, imm_j, npc, val, addr, sval, pc4;
    logic        wr, st, bad, take, ld;
    logic [1:0]  size;

    assign opc   = instr[6:0];
    assign rd    = instr[11:7];
    assign f3    = instr[14:12];
    assign f7    = instr[31:25];
    assign imm_i = {{20{instr[31]}}, instr[31:20]};
    assign imm_s = {{20{instr[31]}}, instr[31:25], instr[11:7]};
    assign imm_b = {{19{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};
    assign imm_j = {{11{instr[31]}}, instr[31], instr[19:12], instr[20], instr[30:21], 1'b0};
    assign pc4   = pc + 32'd4;

    always_comb begin
        npc  = pc4;
        val  = '0;
        addr = '0;
        sval = '0;
        wr   = 1'b0;
        st   = 1'b0;
        bad  = 1'b0;
        take = 1'b0;
        ld   = 1'b0;
        size = SZ_WORD;
        case (opc)
            OP_REG: begin
                wr = 1'b1;
                if (f7 == F7_BASE) begin
                    case (f3)
                        3'd0: val = op_a + op_b;
                        3'd1: val = op_a << op_b[4:0];
                        3'd2: val = {31'd0, $signed(op_a) < $signed(op_b)};
                        3'd4: val = op_a ^ op_b;
                        3'd5: val = op_a >> op_b[4:0];
                        3'd6: val = op_a | op_b;
                        3'd7: val = op_a & op_b;
                        default: bad = 1'b1;
                    endcase
                end else if (f7 == F7_ALT && f3 == 3'd0) begin
                    val = op_a - op_b;
                end else if (f7 == F7_ALT && f3 == 3'd5) begin
                    val = 32'($signed(op_a) >>> op_b[4:0]);
                end else begin
                    bad = 1'b1;
                end
            end
            OP_IMM: begin
                wr = 1'b1;
                if (f3 == 3'd0)                        val = op_a + imm_i;
                else if (f3 == 3'd7)                   val = op_a & imm_i;
                else if (f3 == 3'd6)                   val = op_a | imm_i;
                else if (f3 == 3'd1 && f7 == F7_BASE)  val = op_a << instr[24:20];
                else                                   bad = 1'b1;
            end
            OP_LOAD: begin
                addr = op_a + imm_i;
                wr   = 1'b1;
                ld   = 1'b1;
                if (f3 == 3'd0)      size = SZ_BYTE;
                else if (f3 == 3'd1) size = SZ_HALF;
                else if (f3 == 3'd2) size = SZ_WORD;
                else                 bad  = 1'b1;
            end
            OP_JALR: begin
                if (f3 == 3'd0) begin
                    wr  = 1'b1;
                    val = pc4;
                    npc = (op_a + imm_i) & ~32'd1;
                end else begin
                    bad = 1'b1;
                end
            end
            OP_BRANCH: begin
                case (f3)
                    3'd0: take = (op_a == op_b);
                    3'd1: take = (op_a != op_b);
                    3'd4: take = $signed(op_a) < $signed(op_b);
                    3'd5: take = !($signed(op_a) < $signed(op_b));
                    default: bad = 1'b1;
                endcase
                if (take) npc = pc + imm_b;
            end
            OP_JAL: begin
                wr  = 1'b1;
                val = pc4;
                npc = pc + imm_j;
            end
            OP_STORE: begin
                addr = op_a + imm_s;
                st   = 1'b1;
                if (f3 == 3'd0) begin
                    size = SZ_BYTE;
                    sval = {24'd0, op_b[7:0]};
                end else if (f3 == 3'd1) begin
                    size = SZ_HALF;
                    sval = {16'd0, op_b[15:0]};
                end else if (f3 == 3'd2) begin
                    size = SZ_WORD;
                    sval = op_b;
                end else begin
                    bad = 1'b1;
                end
            end
            OP_LUI: begin
                wr  = 1'b1;
                val = {instr[31:12], 12'd0};
            end
            OP_AUIPC: begin
                wr  = 1'b1;
                val = pc + {instr[31:12], 12'd0};
            end
            default: bad = 1'b1;
        endcase

        ex = '0;
        ex.size = size;
        if (halt_seen || instr == HALT_WORD) begin
            ex.halt_set    = 1'b1;
            ex.res.next_pc = pc;
            ex.res.halted  = 1'b1;
        end else if (bad) begin
            ex.res.next_pc = pc4;
            ex.res.illegal = 1'b1;
        end else begin
            ex.res.next_pc     = npc;
            ex.is_load         = ld;
            ex.res.store_done  = st;
            ex.res.mem_address = addr;
            ex.res.store_value = sval;
            if (wr && rd != 5'd0) begin
                ex.res.reg_written = 1'b1;
                ex.res.dest_reg    = rd;
                // load data is filled in one stage later
                ex.res.write_value = ld ? 32'd0 : val;
            end
        end
    end
endmodule
`default_nettype wire

FILE: sv/rvx_dmem.sv
// Byte-lane data memory with clearing pass after reset.
`default_nettype none
module rvx_dmem #(
    parameter int DATA_WORDS = rvx_pkg::DataWordsDef
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        en,
    input  wire logic        we,
    input  wire logic [31:0] addr,
    input  wire logic [1:0]  size,
    input  wire logic [31:0] wdata,
    output logic [31:0]      rdata,
    output logic             busy
);
    import rvx_pkg::*;

    localparam int AW = $clog2(DATA_WORDS);

    logic [AW-1:0] clr_reg, clr_next;
    logic          busy_reg, busy_next;
    logic [AW-1:0] base;
    logic [1:0]    off;
    logic [2:0]    nbytes;

    assign base   = addr[AW+1:2];
    assign off    = addr[1:0];
    assign nbytes = (size == SZ_BYTE) ? 3'd1 : (size == SZ_HALF) ? 3'd2 : 3'd4;
    assign busy   = busy_reg;

    always_comb begin
        clr_next  = clr_reg + AW'(1);
        busy_next = busy_reg && (clr_reg != AW'(DATA_WORDS - 1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg  <= '0;
            busy_reg <= 1'b1;
        end else if (busy_reg) begin
            clr_reg  <= clr_next;
            busy_reg <= busy_next;
        end
    end

    for (genvar j = 0; j < 4; j++) begin : g_lane
        logic [7:0]    mem [DATA_WORDS];
        logic [1:0]    bidx;
        logic [AW-1:0] widx;
        logic          act;
        logic [7:0]    rd_reg;

        // lanes below the start offset belong to the following word
        assign bidx = 2'(j) - off;
        assign widx = (2'(j) < off) ? base + AW'(1) : base;
        assign act  = {1'b0, bidx} < nbytes;

        always_ff @(posedge aclk) begin
            if (busy_reg) begin
                mem[clr_reg] <= 8'd0;
            end else if (en) begin
                if (we && act) mem[widx] <= wdata[8*bidx +: 8];
                rd_reg <= mem[widx];
            end
        end

        assign rdata[8*j +: 8] = rd_reg;
    end
endmodule
`default_nettype wire

FILE: sv/rv32i_subset_executor_top.sv
// Top level of the RV32I subset executor.
// Usage: each s_ item carries one 32-bit instruction word (s_tdata) fetched
// outside at the pc that the previous result reported (0 after reset).
// Each m_ item carries the execution report: next pc, register writeback,
// store address and value, halted and illegal flags.
// Pipeline: input register, execute/memory stage, output register. One item
// is accepted per cycle while m_tready is high and the memory is not clearing.
// A load result is forwarded from the memory stage to the next item.
// The data memory is split in four byte lanes, one read/write port each, so a
// misaligned access, also one across a word boundary, is served in one access.
// Reset: registers cleared (x2 = last word address), pc 0, and the data
// memory is cleared one word per cycle, with s_tready low.
// When m_tready is low, stages fill up behind the output register and then
// s_tready drops; nothing is lost or repeated.
`default_nettype none
module rv32i_subset_executor_top #(
    parameter int DATA_WORDS = rvx_pkg::DataWordsDef
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [rvx_pkg::TDATA_IN_W-1:0]  s_tdata,  // instr_word
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // next_pc, reg_written, dest_reg, write_value, store_done, mem_address,
    // store_value, halted, illegal, zero fill
    output logic [rvx_pkg::TDATA_OUT_W-1:0]      m_tdata
);
    import rvx_pkg::*;

    logic [31:0] rf_reg [32];
    logic [31:0] pc_reg;
    logic        halt_reg;
    logic        in_v_reg, ex_v_reg, out_v_reg;
    logic [31:0] instr_reg;
    exec_t       ex_reg, ex_now;
    result_t     out_reg, ex_res;
    logic        in_fire, ex_fire, out_ready, ex_ready, s_fire;
    logic [31:0] op_a, op_b, ld_val, mem_rdata;
    logic [4:0]  rs1, rs2;
    logic        mem_busy, fwd_ok;

    assign rs1 = instr_reg[19:15];
    assign rs2 = instr_reg[24:20];

    assign out_ready = !out_v_reg || m_tready;
    assign ex_ready  = !ex_v_reg || out_ready;
    assign in_fire   = in_v_reg && ex_ready;
    assign ex_fire   = ex_v_reg && out_ready;
    assign s_tready  = (!in_v_reg || ex_ready) && !mem_busy;
    assign s_fire    = s_tvalid && s_tready;

    assign ld_val = load_value(mem_rdata, ex_reg.res.mem_address[1:0], ex_reg.size);
    assign fwd_ok = ex_v_reg && ex_reg.is_load && ex_reg.res.reg_written;

    always_comb begin
        op_a = rf_reg[rs1];
        op_b = rf_reg[rs2];
        if (fwd_ok && ex_reg.res.dest_reg == rs1) op_a = ld_val;
        if (fwd_ok && ex_reg.res.dest_reg == rs2) op_b = ld_val;
        ex_res = ex_reg.res;
        if (ex_reg.is_load && ex_reg.res.reg_written) ex_res.write_value = ld_val;
    end

    rvx_exec u_exec (
        .instr     (instr_reg),
        .pc        (pc_reg),
        .op_a      (op_a),
        .op_b      (op_b),
        .halt_seen (halt_reg),
        .ex        (ex_now)
    );

    rvx_dmem #(.DATA_WORDS(DATA_WORDS)) u_dmem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (in_fire && (ex_now.is_load || ex_now.res.store_done)),
        .we      (ex_now.res.store_done),
        .addr    (ex_now.res.mem_address),
        .size    (ex_now.size),
        .wdata   (op_b),
        .rdata   (mem_rdata),
        .busy    (mem_busy)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 32; i++)
                rf_reg[i] <= (i == 2) ? 32'(DATA_WORDS * 4 - 4) : '0;
            pc_reg    <= '0;
            halt_reg  <= 1'b0;
            in_v_reg  <= 1'b0;
            ex_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end else begin
            if (s_fire)       in_v_reg <= 1'b1;
            else if (in_fire) in_v_reg <= 1'b0;
            if (in_fire)      ex_v_reg <= 1'b1;
            else if (ex_fire) ex_v_reg <= 1'b0;
            if (ex_fire)        out_v_reg <= 1'b1;
            else if (m_tready)  out_v_reg <= 1'b0;

            // load writeback, unless the younger item writes the same register with a non-load result
            if (ex_fire && ex_reg.is_load && ex_reg.res.reg_written &&
                !(in_fire && ex_now.res.reg_written && !ex_now.is_load &&
                  ex_now.res.dest_reg == ex_reg.res.dest_reg))
                rf_reg[ex_reg.res.dest_reg] <= ld_val;
            if (in_fire) begin
                pc_reg <= ex_now.res.next_pc;
                if (ex_now.halt_set) halt_reg <= 1'b1;
                if (ex_now.res.reg_written && !ex_now.is_load)
                    rf_reg[ex_now.res.dest_reg] <= ex_now.res.write_value;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire)  instr_reg <= s_tdata[31:0];
        if (in_fire) ex_reg    <= ex_now;
        if (ex_fire) out_reg   <= ex_res;
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {7'd0, out_reg.illegal, out_reg.halted, out_reg.store_value,
                       out_reg.mem_address, out_reg.store_done, out_reg.write_value,
                       out_reg.dest_reg, out_reg.reg_written, out_reg.next_pc};
endmodule
`default_nettype wire

FILE: tb/sv/rv32i_subset_executor_top_test.sv
// Self-checking testbench for the RV32I subset executor: directed and random instruction streams.
`default_nettype none
module rv32i_subset_executor_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import rvx_pkg::*;

    localparam int      MemWords = DataWordsDef;
    localparam int      NumRandom = 900;
    localparam int      PauseAt = 450;
    localparam int      MaxReports = 10;
    localparam int      DrainCycles = 20;
    localparam int      RunLimitNs = 3_000_000;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SRX  = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [TDATA_IN_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [TDATA_OUT_W-1:0] m_tdata;

    rv32i_subset_executor_top DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // architectural state mirror
    logic [31:0] regs [32];
    logic [31:0] dmem [MemWords];
    logic [31:0] pc_now;
    logic        halt_flag;

    logic [31:0] instr_q [$];
    result_t     report_q [$];
    int          accepted = 0;
    int          mismatches = 0;
    bit          paused_done = 0;

    function automatic logic [7:0] rd_byte(logic [31:0] addr);
        logic [31:0] b;
        b = addr % (MemWords * 4);
        return dmem[b >> 2][8*b[1:0] +: 8];
    endfunction

    function automatic void wr_byte(logic [31:0] addr, logic [7:0] v);
        logic [31:0] b;
        b = addr % (MemWords * 4);
        dmem[b >> 2][8*b[1:0] +: 8] = v;
    endfunction

    function automatic logic [31:0] rd_bytes(logic [31:0] addr, int n);
        logic [31:0] v;
        v = '0;
        for (int i = 0; i < n; i++) v[8*i +: 8] = rd_byte(addr + 32'(i));
        return v;
    endfunction

    function automatic result_t execute(logic [31:0] ins);
        result_t     r;
        logic [6:0]  opc;
        logic [4:0]  rd;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic [31:0] a, b, imm_i, imm_s, imm_b, imm_j, npc, val, addr, sval;
        bit          wr, st, bad, take;
        r = '0;
        opc = ins[6:0]; rd = ins[11:7]; f3 = ins[14:12]; f7 = ins[31:25];
        a = regs[ins[19:15]]; b = regs[ins[24:20]];
        imm_i = {{20{ins[31]}}, ins[31:20]};
        imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
        imm_b = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
        imm_j = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
        npc = pc_now + 32'd4; val = '0; addr = '0; sval = '0;
        wr = 0; st = 0; bad = 0; take = 0;
        if (halt_flag || ins == HALT_WORD) begin
            halt_flag = 1'b1;
            r.next_pc = pc_now;
            r.halted = 1'b1;
            return r;
        end
        case (opc)
            OP_REG: begin
                wr = 1;
                if (f7 == F7_BASE) begin
                    case (f3)
                        F3_ADD: val = a + b;
                        F3_SLL: val = a << b[4:0];
                        F3_SLT: val = {31'd0, $signed(a) < $signed(b)};
                        F3_XOR: val = a ^ b;
                        F3_SRX: val = a >> b[4:0];
                        F3_OR:  val = a | b;
                        F3_AND: val = a & b;
                        default: bad = 1;
                    endcase
                end else if (f7 == F7_ALT && f3 == F3_ADD) begin
                    val = a - b;
                end else if (f7 == F7_ALT && f3 == F3_SRX) begin
                    val = $unsigned($signed(a) >>> b[4:0]);
                end else begin
                    bad = 1;
                end
            end
            OP_IMM: begin
                wr = 1;
                if (f3 == F3_ADD) val = a + imm_i;
                else if (f3 == F3_AND) val = a & imm_i;
                else if (f3 == F3_OR) val = a | imm_i;
                else if (f3 == F3_SLL && f7 == F7_BASE) val = a << ins[24:20];
                else bad = 1;
            end
            OP_LOAD: begin
                addr = a + imm_i;
                wr = 1;
                if (f3 == 3'(SZ_BYTE)) begin
                    val = rd_bytes(addr, 1);
                    val = {{24{val[7]}}, val[7:0]};
                end else if (f3 == 3'(SZ_HALF)) begin
                    val = rd_bytes(addr, 2);
                    val = {{16{val[15]}}, val[15:0]};
                end else if (f3 == 3'(SZ_WORD)) begin
                    val = rd_bytes(addr, 4);
                end else begin
                    bad = 1;
                end
            end
            OP_JALR: begin
                if (f3 == F3_ADD) begin
                    wr = 1;
                    val = pc_now + 32'd4;
                    npc = (a + imm_i) & ~32'd1;
                end else begin
                    bad = 1;
                end
            end
            OP_BRANCH: begin
                case (f3)
                    F3_BEQ: take = (a == b);
                    F3_BNE: take = (a != b);
                    F3_BLT: take = $signed(a) < $signed(b);
                    F3_BGE: take = !($signed(a) < $signed(b));
                    default: bad = 1;
                endcase
                if (take) npc = pc_now + imm_b;
            end
            OP_JAL: begin
                wr = 1;
                val = pc_now + 32'd4;
                npc = pc_now + imm_j;
            end
            OP_STORE: begin
                addr = a + imm_s;
                st = 1;
                if (f3 == 3'(SZ_BYTE)) sval = b & 32'hFF;
                else if (f3 == 3'(SZ_HALF)) sval = b & 32'hFFFF;
                else if (f3 == 3'(SZ_WORD)) sval = b;
                else bad = 1;
                if (!bad)
                    for (int i = 0; i < (1 << f3[1:0]); i++)
                        wr_byte(addr + 32'(i), b[8*i +: 8]);
            end
            OP_LUI:   begin wr = 1; val = {ins[31:12], 12'd0}; end
            OP_AUIPC: begin wr = 1; val = pc_now + {ins[31:12], 12'd0}; end
            default:  bad = 1;
        endcase
        if (bad) begin
            pc_now = pc_now + 32'd4;
            r.next_pc = pc_now;
            r.illegal = 1'b1;
            return r;
        end
        if (wr && rd != 5'd0) begin
            regs[rd] = val;
            r.reg_written = 1'b1;
            r.dest_reg = rd;
            r.write_value = val;
        end
        pc_now = npc;
        r.next_pc = npc;
        r.store_done = st;
        r.mem_address = addr;
        r.store_value = sval;
        return r;
    endfunction

    function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3, logic [4:0] rd, logic [6:0] op);
        return {f7, rs2, rs1, f3, rd, op};
    endfunction

    function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                          logic [4:0] rd, logic [6:0] op);
        return {imm, rs1, f3, rd, op};
    endfunction

    function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
    endfunction

    function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3);
        return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OP_BRANCH};
    endfunction

    function automatic logic [31:0] enc_j(logic [20:0] imm, logic [4:0] rd);
        return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OP_JAL};
    endfunction

    // mostly well-formed instructions with random operands; some raw noise
    function automatic logic [31:0] rand_instr();
        logic [31:0] w;
        logic [4:0]  rd, rs1, rs2;
        logic [2:0]  f3;
        logic [2:0]  alu_ops [7];
        int          kind;
        alu_ops = '{F3_ADD, F3_SLL, F3_SLT, F3_XOR, F3_SRX, F3_OR, F3_AND};
        rd = 5'($urandom); rs1 = 5'($urandom); rs2 = 5'($urandom);
        w = $urandom;
        kind = $urandom_range(0, 19);
        case (kind)
            0, 1, 2: begin
                f3 = alu_ops[$urandom_range(0, 6)];
                return enc_r(((f3 == F3_ADD || f3 == F3_SRX) && $urandom_range(0, 1))
                             ? F7_ALT : F7_BASE, rs2, rs1, f3, rd, OP_REG);
            end
            3, 4: begin
                f3 = alu_ops[$urandom_range(0, 6)];
                if (f3 == F3_SLL) return enc_i({F7_BASE, w[4:0]}, rs1, f3, rd, OP_IMM);
                if (f3 == F3_SLT || f3 == F3_XOR || f3 == F3_SRX) f3 = F3_ADD;
                return enc_i(w[11:0], rs1, f3, rd, OP_IMM);
            end
            5, 6, 7: return enc_i(w[11:0], $urandom_range(0, 1) ? 5'd2 : rs1,
                                  3'($urandom_range(0, 2)), rd, OP_LOAD);
            8, 9, 10: return enc_s(w[11:0], rs2, $urandom_range(0, 1) ? 5'd2 : rs1,
                                   3'($urandom_range(0, 2)));
            11, 12: return enc_b(w[12:0], rs2, rs1,
                                 $urandom_range(0, 1) ? 3'($urandom_range(0, 1))
                                                      : 3'($urandom_range(4, 5)));
            13: return enc_j(w[20:0], rd);
            14: return enc_i(w[11:0], rs1, F3_ADD, rd, OP_JALR);
            15: return {w[31:12], rd, OP_LUI};
            16: return {w[31:12], rd, OP_AUIPC};
            17: return {w[31:15], 3'($urandom_range(3, 7)), w[11:7], OP_LOAD};
            default: return (w == HALT_WORD) ? ~w : w;
        endcase
    endfunction

    // driver
    int gap_left = 0;
    bit busy_mode = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                report_q.push_back(execute(s_tdata));
                accepted++;
            end
            if (!(s_tvalid && !s_tready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (accepted >= PauseAt && !paused_done) begin
                    s_tvalid <= 1'b0;
                    if (report_q.size() == 0 && !s_tvalid) paused_done = 1;
                end else if (instr_q.size() != 0) begin
                    s_tdata <= instr_q.pop_front();
                    s_tvalid <= 1'b1;
                    if ($urandom_range(0, 99) == 0) busy_mode = !busy_mode;
                    gap_left = busy_mode ? 0 : $urandom_range(0, 6);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    int stall_left = 0;
    bit fast_sink = 0;
    always @(posedge aclk) begin
        result_t got, want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.next_pc     = m_tdata[31:0];
                got.reg_written = m_tdata[32];
                got.dest_reg    = m_tdata[37:33];
                got.write_value = m_tdata[69:38];
                got.store_done  = m_tdata[70];
                got.mem_address = m_tdata[102:71];
                got.store_value = m_tdata[134:103];
                got.halted      = m_tdata[135];
                got.illegal     = m_tdata[136];
                if (report_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MaxReports)
                        $display("unexpected result item: %p", got);
                end else begin
                    want = report_q.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= MaxReports)
                            $display("mismatch: expected %p, actual %p", want, got);
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (m_tvalid) begin
                    if ($urandom_range(0, 99) == 0) fast_sink = !fast_sink;
                    stall_left = fast_sink ? 0 : $urandom_range(0, 6);
                end
            end
        end
    end

    initial begin
        #RunLimitNs;
        $display("rv32i_subset_executor_top_test failed");
        $finish;
    end

    initial begin
        foreach (regs[i]) regs[i] = '0;
        foreach (dmem[i]) dmem[i] = '0;
        regs[2] = 32'(MemWords * 4 - 4);
        pc_now = '0;
        halt_flag = 1'b0;

        instr_q.push_back({20'h80000, 5'd1, OP_LUI});
        instr_q.push_back(enc_i(12'hFFF, 5'd0, F3_ADD, 5'd3, OP_IMM));
        instr_q.push_back(enc_i(12'h7FF, 5'd0, F3_ADD, 5'd4, OP_IMM));
        instr_q.push_back(enc_r(F7_ALT, 5'd4, 5'd1, F3_SRX, 5'd5, OP_REG));
        instr_q.push_back(enc_r(F7_BASE, 5'd4, 5'd1, F3_SRX, 5'd6, OP_REG));
        instr_q.push_back(enc_r(F7_BASE, 5'd4, 5'd3, F3_SLL, 5'd7, OP_REG));
        instr_q.push_back(enc_r(F7_BASE, 5'd3, 5'd1, F3_SLT, 5'd8, OP_REG));
        instr_q.push_back(enc_r(F7_ALT, 5'd3, 5'd0, F3_ADD, 5'd9, OP_REG));
        instr_q.push_back(enc_r(F7_BASE, 5'd4, 5'd1, F3_XOR, 5'd10, OP_REG));
        instr_q.push_back(enc_r(F7_BASE, 5'd3, 5'd3, F3_ADD, 5'd0, OP_REG));
        instr_q.push_back(enc_i({F7_BASE, 5'd31}, 5'd3, F3_SLL, 5'd11, OP_IMM));
        // word store straddling the top of memory, read back as a word and as a halfword
        instr_q.push_back(enc_s(12'hFFF, 5'd1, 5'd0, 3'(SZ_WORD)));
        instr_q.push_back(enc_i(12'hFFF, 5'd0, 3'(SZ_WORD), 5'd12, OP_LOAD));
        instr_q.push_back(enc_i(12'h002, 5'd0, 3'(SZ_HALF), 5'd13, OP_LOAD));
        instr_q.push_back(enc_s(12'h001, 5'd3, 5'd2, 3'(SZ_HALF)));
        instr_q.push_back(enc_s(12'h800, 5'd3, 5'd2, 3'(SZ_BYTE)));
        instr_q.push_back(enc_i(12'h800, 5'd2, 3'(SZ_BYTE), 5'd14, OP_LOAD));
        instr_q.push_back(enc_b(13'd8, 5'd0, 5'd0, F3_BEQ));
        instr_q.push_back(enc_b(13'h1FFC, 5'd3, 5'd1, F3_BLT));
        instr_q.push_back(enc_b(13'h1000, 5'd1, 5'd3, F3_BGE));
        instr_q.push_back(enc_b(13'd16, 5'd0, 5'd0, F3_BNE));
        instr_q.push_back(enc_j(21'h1FFFFC, 5'd1));
        instr_q.push_back(enc_i(12'h000, 5'd3, F3_ADD, 5'd15, OP_JALR));
        instr_q.push_back({20'hFFFFF, 5'd16, OP_AUIPC});
        instr_q.push_back(enc_r(7'b0000001, 5'd1, 5'd1, F3_ADD, 5'd17, OP_REG));
        instr_q.push_back(enc_i(12'h123, 5'd1, F3_SLT, 5'd18, OP_IMM));
        instr_q.push_back(enc_b(13'd8, 5'd1, 5'd1, 3'd2));
        instr_q.push_back(enc_i(12'h000, 5'd1, 3'd1, 5'd19, OP_JALR));
        instr_q.push_back(32'hFFFF_FFFF);
        for (int i = 0; i < NumRandom; i++) instr_q.push_back(rand_instr());
        instr_q.push_back(HALT_WORD);
        for (int i = 0; i < 4; i++) instr_q.push_back(rand_instr());

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        do @(posedge aclk); while (instr_q.size() != 0 || s_tvalid || report_q.size() != 0);
        repeat (DrainCycles) @(posedge aclk);
        if (mismatches == 0 && report_q.size() == 0)
            $display("rv32i_subset_executor_top_test passed");
        else
            $display("rv32i_subset_executor_top_test failed");
        $finish;
    end
endmodule
`default_nettype wire
